### hdl/lgw_pkg.sv
// Shared types, operation codes, register indexes and pixel format helpers.
package lgw_pkg;

	localparam logic [2:0] OP_SET_CURSOR = 3'd0;
	localparam logic [2:0] OP_SET_WINDOW = 3'd1;
	localparam logic [2:0] OP_WRITE      = 3'd2;
	localparam logic [2:0] OP_READ       = 3'd3;
	localparam logic [2:0] OP_FILL       = 3'd4;

	localparam logic REG_COORD_OFFSET = 1'b0;
	localparam logic REG_RB_SWAP      = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic set_cursor;
		logic set_window;
		logic calc_addr;
		logic write_pix;
		logic read_pix;
		logic clr_step;
		logic result;
		logic result_read;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] op;
		logic       count_zero;
		logic       count_one;
		logic       in_win;
		logic       clr_last;
	} sts_t;

	// RGB565 to RGB888, red and blue exchanged in BGR mode.
	function automatic logic [23:0] expand565(input logic [15:0] c, input logic bgr);
		logic [23:0] w;
		if (bgr) begin
			w = {c[4:0], 3'b000, c[10:5], 2'b00, c[15:11], 3'b000};
		end else begin
			w = {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
		end
		return w;
	endfunction

	// Stored RGB888 word back to 16 bits with its outer channels exchanged: the low channel goes on top.
	function automatic logic [15:0] pack888(input logic [23:0] w);
		return {w[7:3], w[15:10], w[23:19]};
	endfunction

endpackage

### hdl/lcd_gram_window_writer.sv
// Top level of the LCD graphics RAM window writer: register port, controller and datapath.
//
// Usage: a command word (operation, position, window size, colour, fill count) is taken
// at a rising edge where start is high and busy is low. Each command gives exactly one
// result word: done is high for one cycle while read_color, cursor_x and cursor_y hold
// the read pixel (zero unless a read inside the frame) and the cursor after the command.
// The receiver cannot hold results off; they are registered and shown for one cycle.
// Set cursor, set window, unknown operations and an empty fill go straight to the result;
// a write or a read handles one pixel, and a fill of N pixels repeats this for each pixel
// (fewer when the cursor leaves the window). Each pixel passes an address state, where
// the row times frame width product is registered, and then a store state on the frame
// RAM's single write port, or a read state for a read. busy falls in the cycle done rises,
// so the next command may be taken while the previous result is shown.
// Reset: the cursor and window clear to zero and the frame store is cleared by a pass over
// all FRAME_WIDTH * FRAME_HEIGHT addresses (76800 at the defaults), during which busy is
// high. The register port (coord_offset at 0x0, rb_swap at 0x4) takes writes at any
// time, including during the clearing pass, but should only be written while idle.
module lcd_gram_window_writer #(
	parameter int FRAME_WIDTH  = 320,
	parameter int FRAME_HEIGHT = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [9:0]  pos_x,
	input  logic [9:0]  pos_y,
	input  logic [10:0] win_width,
	input  logic [10:0] win_height,
	input  logic [15:0] color,
	input  logic [16:0] fill_count,
	// Result channel
	output logic        done,
	output logic [15:0] read_color,
	output logic [10:0] cursor_x,
	output logic [10:0] cursor_y,
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [9:0]    coord_offset_q;
	logic          rb_swap_q;
	logic          reg_wr;
	lgw_pkg::cmd_t cmd;
	lgw_pkg::sts_t sts;

	// Registers are word aligned, so bit 2 of the address selects one of the two.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_offset_q <= '0;
			rb_swap_q      <= 1'b0;
		end else if (reg_wr) begin
			unique case (paddr[2])
				lgw_pkg::REG_COORD_OFFSET: coord_offset_q <= pwdata[9:0];
				lgw_pkg::REG_RB_SWAP:      rb_swap_q      <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lgw_pkg::REG_COORD_OFFSET: prdata = {22'd0, coord_offset_q};
			lgw_pkg::REG_RB_SWAP:      prdata = {31'd0, rb_swap_q};
		endcase
	end

	// The controller sequences each command; the datapath holds all cursor, window and
	// pixel state and the frame store itself.
	lgw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lgw_datapath #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.win_width    (win_width),
		.win_height   (win_height),
		.color        (color),
		.fill_count   (fill_count),
		.coord_offset (coord_offset_q),
		.rb_swap      (rb_swap_q),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.read_color   (read_color),
		.cursor_x     (cursor_x),
		.cursor_y     (cursor_y)
	);

	// An accepted command always keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command accepted but block not busy afterwards");

	// A result command from the controller shows up as a result word in the next cycle.
	a_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |=> done)
		else $error("result command did not produce a result word");

	// Each command gives a single result word, never two in a row.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A result word is only shown once the controller is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word shown while still busy");

	// The frame store is never cleared and written by a command at the same time.
	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !cmd.write_pix && busy)
		else $error("clearing pass overlaps a pixel write");

endmodule

### hdl/lgw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lgw_ram #(
	parameter int WIDTH  = 24,
	parameter int DEPTH  = 76800,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/lgw_ctrl.sv
// Sequencing state machine for the graphics RAM window writer.
module lgw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lgw_pkg::sts_t sts,
	output lgw_pkg::cmd_t cmd,
	output logic          busy
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_ADDR   = 3'd3;
	localparam logic [2:0] ST_WRITE  = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_RESULT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.op)
					lgw_pkg::OP_SET_CURSOR: begin
						cmd.set_cursor = 1'b1;
						state_d        = ST_RESULT;
					end
					lgw_pkg::OP_SET_WINDOW: begin
						cmd.set_window = 1'b1;
						state_d        = ST_RESULT;
					end
					lgw_pkg::OP_WRITE, lgw_pkg::OP_READ: begin
						state_d = ST_ADDR;
					end
					lgw_pkg::OP_FILL: begin
						state_d = sts.count_zero ? ST_RESULT : ST_ADDR;
					end
					default: begin
						state_d = ST_RESULT;
					end
				endcase
			end
			ST_ADDR: begin
				cmd.calc_addr = 1'b1;
				state_d       = (sts.op == lgw_pkg::OP_READ) ? ST_READ : ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write_pix = 1'b1;
				if (sts.op == lgw_pkg::OP_FILL && sts.in_win && !sts.count_one) begin
					state_d = ST_ADDR;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_READ: begin
				cmd.read_pix = 1'b1;
				state_d      = ST_RESULT;
			end
			ST_RESULT: begin
				cmd.result      = 1'b1;
				cmd.result_read = (sts.op == lgw_pkg::OP_READ);
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### hdl/lgw_datapath.sv
// Cursor, window, address and frame store datapath of the window writer.
module lgw_datapath #(
	parameter int FRAME_WIDTH  = 320,
	parameter int FRAME_HEIGHT = 240
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [2:0]    operation,
	input  logic [9:0]    pos_x,
	input  logic [9:0]    pos_y,
	input  logic [10:0]   win_width,
	input  logic [10:0]   win_height,
	input  logic [15:0]   color,
	input  logic [16:0]   fill_count,
	input  logic [9:0]    coord_offset,
	input  logic          rb_swap,
	input  lgw_pkg::cmd_t cmd,
	output lgw_pkg::sts_t sts,
	output logic          done,
	output logic [15:0]   read_color,
	output logic [10:0]   cursor_x,
	output logic [10:0]   cursor_y
);

	localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Latched item
	logic [2:0]  op_q;
	logic [9:0]  px_q;
	logic [9:0]  py_q;
	logic [10:0] ww_q;
	logic [10:0] wh_q;
	logic [15:0] color_q;
	logic [16:0] count_q;

	// Cursor and window
	logic [10:0] cursor_col_q;
	logic [10:0] cursor_row_q;
	logic [10:0] win_xs_q;
	logic [11:0] win_xe_q;
	logic [10:0] win_ys_q;
	logic [11:0] win_ye_q;

	logic [ADDR_W-1:0] addr_q;
	logic              in_win_q;
	logic              in_frame_q;
	logic [ADDR_W-1:0] clr_q;

	logic [15:0] read_color_q;
	logic [10:0] cursor_x_q;
	logic [10:0] cursor_y_q;
	logic        done_q;

	logic [21:0] lin_addr;
	logic        in_win;
	logic        in_frame;
	logic        col_at_end;
	logic        row_at_end;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [23:0]       ram_wdata;
	logic [23:0]       ram_rdata;

	assign in_win = (cursor_col_q >= win_xs_q) && ({1'b0, cursor_col_q} <= win_xe_q) &&
		(cursor_row_q >= win_ys_q) && ({1'b0, cursor_row_q} <= win_ye_q);
	assign in_frame = (cursor_col_q < 11'(FRAME_WIDTH)) && (cursor_row_q < 11'(FRAME_HEIGHT));
	assign lin_addr = 22'(cursor_row_q) * 22'(FRAME_WIDTH) + 22'(cursor_col_q);

	assign col_at_end = ({1'b0, cursor_col_q} == win_xe_q);
	assign row_at_end = ({1'b0, cursor_row_q} == win_ye_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			px_q    <= pos_x;
			py_q    <= pos_y;
			ww_q    <= win_width;
			wh_q    <= win_height;
			color_q <= color;
		end
		if (cmd.calc_addr) begin
			addr_q     <= lin_addr[ADDR_W-1:0];
			in_win_q   <= in_win;
			in_frame_q <= in_frame;
		end
		if (cmd.result) begin
			read_color_q <= (cmd.result_read && in_frame_q) ? lgw_pkg::pack888(ram_rdata) : '0;
			cursor_x_q   <= cursor_col_q;
			cursor_y_q   <= cursor_row_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			count_q <= fill_count;
		end else if (cmd.write_pix && in_win_q) begin
			count_q <= count_q - 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			win_xs_q     <= '0;
			win_xe_q     <= '0;
			win_ys_q     <= '0;
			win_ye_q     <= '0;
			clr_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.result;
			if (cmd.clr_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.set_cursor) begin
				cursor_col_q <= 11'(px_q) + 11'(coord_offset);
				cursor_row_q <= 11'(py_q) + 11'(coord_offset);
			end else if (cmd.write_pix && in_win_q) begin
				if (col_at_end) begin
					cursor_col_q <= win_xs_q;
					cursor_row_q <= row_at_end ? win_ys_q : cursor_row_q + 11'd1;
				end else begin
					cursor_col_q <= cursor_col_q + 11'd1;
				end
			end
			if (cmd.set_window) begin
				// End is start plus size minus one, wrapping at 12 bits.
				win_xs_q <= 11'(px_q) + 11'(coord_offset);
				win_xe_q <= 12'(px_q) + 12'(ww_q) + 12'(coord_offset) - 12'd1;
				win_ys_q <= 11'(py_q) + 11'(coord_offset);
				win_ye_q <= 12'(py_q) + 12'(wh_q) + 12'(coord_offset) - 12'd1;
			end
		end
	end

	assign ram_we    = cmd.clr_step || (cmd.write_pix && in_win_q && in_frame_q);
	assign ram_waddr = cmd.clr_step ? clr_q : addr_q;
	assign ram_wdata = cmd.clr_step ? '0 : lgw_pkg::expand565(color_q, rb_swap);

	lgw_ram #(
		.WIDTH  (24),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.read_pix),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign sts.op         = op_q;
	assign sts.count_zero = (count_q == 17'd0);
	assign sts.count_one  = (count_q == 17'd1);
	assign sts.in_win     = in_win_q;
	assign sts.clr_last   = (clr_q == ADDR_W'(DEPTH - 1));

	assign done       = done_q;
	assign read_color = read_color_q;
	assign cursor_x   = cursor_x_q;
	assign cursor_y   = cursor_y_q;

endmodule
